// ----- sv/pfd_pkg.sv -----
// Shared types, constants and helper functions of the PWM timer set-up block.
package pfd_pkg;

	localparam int NUM_PRESCALERS = 5;
	localparam int NUM_CH_MAX = 3;
	localparam int DUTY_SHIFT = 8;
	localparam int MIN_TOP_EXCL = 3;
	localparam int FREQ_BITS = 24;
	localparam int DIVISOR_BITS = FREQ_BITS + 1;

	localparam logic FUNC_SET_FREQ = 1'b0;
	localparam logic FUNC_SET_DUTY = 1'b1;

	localparam logic [2:0] LAST_PRESCALE = 3'(NUM_PRESCALERS - 1);

	typedef struct packed {
		logic        func;
		logic [23:0] frequency;
		logic [1:0]  channel;
		logic [7:0]  duty;
	} cmd_t;

	typedef struct packed {
		logic        ok;
		logic [15:0] period_top;
		logic [2:0]  clock_select;
		logic [15:0] compare_a;
		logic [15:0] compare_b;
		logic [15:0] compare_c;
		logic [2:0]  output_enables;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SEARCH,
		ST_MUL,
		ST_DONE
	} state_t;

	// Prescalers 1, 8, 64, 256 and 1024 as right shifts of the base quotient.
	function automatic logic [3:0] prescale_shift(input logic [2:0] idx);
		logic [3:0] sh;
		case (idx)
			3'd0: sh = 4'd0;
			3'd1: sh = 4'd3;
			3'd2: sh = 4'd6;
			3'd3: sh = 4'd8;
			3'd4: sh = 4'd10;
			default: sh = 4'd0;
		endcase
		return sh;
	endfunction

endpackage

// ----- sv/pfd_div.sv -----
// Restoring shift-subtract divider that produces one quotient bit per cycle.
module pfd_div import pfd_pkg::*; #(
	parameter int DW = 24
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [DW-1:0]           dividend,
	input  logic [DIVISOR_BITS-1:0] divisor,
	output logic                    done,
	output logic [DW-1:0]           quotient
);

	localparam int CW = $clog2(DW + 1);
	localparam logic [CW-1:0] LAST_STEP = CW'(DW - 1);

	logic                    running_q;
	logic                    done_q;
	logic [CW-1:0]           cnt_q;
	logic [DIVISOR_BITS-1:0] rem_q;
	logic [DIVISOR_BITS-1:0] divisor_q;
	logic [DW-1:0]           quo_q;
	logic [DIVISOR_BITS:0]   trial;
	logic [DIVISOR_BITS:0]   diff;

	assign trial = {rem_q, quo_q[DW-1]};
	assign diff = trial - {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				running_q <= 1'b1;
				cnt_q <= '0;
			end else if (running_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP) begin
					running_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			divisor_q <= divisor;
		end else if (running_q) begin
			if (!diff[DIVISOR_BITS]) begin
				rem_q <= diff[DIVISOR_BITS-1:0];
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= trial[DIVISOR_BITS-1:0];
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule

// ----- sv/pwm_frequency_and_duty_setup.sv -----
// Top level of the PWM timer set-up block: sequencer, timer settings and channel compares.

// Each item is taken when start is high and busy is low, and its result is shown for one
// cycle with done high; the result must be captured then, as it cannot be held off.
// A set-frequency item runs from the accepting cycle through the divider, which gives one
// quotient bit per cycle and then hands the quotient over; the search tries the prescalers in
// turn, the shared multiplier works out the channel compares one by one, and then comes the
// result cycle. A set-duty item passes through the multiplier for its one channel and then
// the result cycle, and a rejected request with zero frequency or a bad channel goes directly
// to the result cycle. busy stays high from the cycle after acceptance through the result
// cycle.
module pwm_frequency_and_duty_setup import pfd_pkg::*; #(
	parameter int CLOCK_HZ = 16000000,
	parameter int COUNTER_BITS = 16,
	parameter int CHANNELS = 3
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  cmd_t    cmd,
	output logic    busy,
	output logic    done,
	output result_t result
);

	localparam int DW = $clog2(CLOCK_HZ + 1);
	localparam logic [DW-1:0] CLOCK_VAL = DW'(CLOCK_HZ);
	localparam logic [DW-1:0] TOP_MAX = DW'((1 << COUNTER_BITS) - 1);
	localparam logic [DW-1:0] TOP_MIN = DW'(MIN_TOP_EXCL);
	localparam logic [1:0] LAST_CH = 2'(CHANNELS - 1);
	localparam logic [1:0] CH_LIMIT = 2'(CHANNELS);

	state_t      state_q;
	state_t      state_d;
	logic        accept;
	logic        ch_valid;
	logic        div_start;
	logic        div_done;
	logic [DW-1:0] div_quo;
	logic [DW-1:0] cand;
	logic        fits;
	logic        take;
	logic [23:0] prod;

	logic [2:0]  psel_q;
	logic [1:0]  ch_q;
	logic [1:0]  last_q;
	logic        ok_q;
	logic [15:0] top_q;
	logic [2:0]  code_q;
	logic [7:0]  duty_q [NUM_CH_MAX];
	logic [15:0] cmp_q [NUM_CH_MAX];
	logic [2:0]  en_q;

	assign accept = start && !busy;
	assign ch_valid = cmd.channel < CH_LIMIT;
	assign cand = div_quo >> prescale_shift(psel_q);
	assign fits = (cand > TOP_MIN) && (cand <= TOP_MAX);
	assign take = fits && (cand < TOP_MAX);
	assign prod = top_q * duty_q[ch_q];

	pfd_div #(
		.DW(DW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (CLOCK_VAL),
		.divisor  ({cmd.frequency, 1'b0}),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		div_start = 1'b0;
		busy = 1'b1;
		done = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					if (cmd.func == FUNC_SET_FREQ) begin
						if (cmd.frequency == '0) begin
							state_d = ST_DONE;
						end else begin
							div_start = 1'b1;
							state_d = ST_DIV;
						end
					end else if (ch_valid) begin
						state_d = ST_MUL;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (take) begin
					state_d = ST_MUL;
				end else if (fits || psel_q == LAST_PRESCALE) begin
					state_d = ST_DONE;
				end
			end
			ST_MUL: begin
				if (ch_q == last_q) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				done = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			psel_q <= '0;
			ch_q <= '0;
			last_q <= '0;
			ok_q <= 1'b0;
			top_q <= '0;
			code_q <= '0;
			en_q <= '0;
			for (int i = 0; i < NUM_CH_MAX; i++) begin
				duty_q[i] <= '0;
				cmp_q[i] <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						ok_q <= 1'b0;
						psel_q <= '0;
						if (cmd.func == FUNC_SET_DUTY) begin
							ch_q <= cmd.channel;
							last_q <= cmd.channel;
							if (ch_valid) begin
								duty_q[cmd.channel] <= cmd.duty;
								ok_q <= 1'b1;
							end
						end else begin
							ch_q <= '0;
							last_q <= LAST_CH;
						end
					end
				end
				ST_SEARCH: begin
					if (take) begin
						top_q <= cand[15:0];
						code_q <= psel_q + 3'd1;
						ok_q <= 1'b1;
					end else if (!fits) begin
						psel_q <= psel_q + 3'd1;
					end
				end
				ST_MUL: begin
					cmp_q[ch_q] <= prod[23:DUTY_SHIFT];
					en_q[ch_q] <= 1'b1;
					ch_q <= ch_q + 2'd1;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		result.ok = ok_q;
		result.period_top = top_q;
		result.clock_select = code_q;
		result.compare_a = cmp_q[0];
		result.compare_b = cmp_q[1];
		result.compare_c = cmp_q[2];
		result.output_enables = en_q;
	end

`ifndef ASSERT_OFF
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n) done |-> busy)
		else $error("result shown while the block reports idle");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not make the block busy");
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.clock_select <= 3'(NUM_PRESCALERS)))
		else $error("clock select code out of range");
	a_mul_channel: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> (ch_q <= last_q))
		else $error("channel sweep ran past its last channel");
`endif

endmodule

// ----- verif/tb.sv -----
// Testbench for the PWM timer set-up block: directed and random items checked against a predictor.
module tb;
	import pfd_pkg::*;

	localparam int CLK_HZ = 16000000;
	localparam int RANDOM_ITEMS = 950;
	localparam int CYCLE_LIMIT = 400000;

	class pwm_setup_scoreboard;
		logic [15:0] top_value;
		logic [2:0] prescale_code;
		logic [7:0] duty_reg[NUM_CH_MAX];
		logic [15:0] compare_reg[NUM_CH_MAX];
		logic [2:0] enable_bits;
		result_t expected_settings[$];
		int fails;

		function new();
			top_value = '0;
			prescale_code = '0;
			enable_bits = '0;
			fails = 0;
			for (int i = 0; i < NUM_CH_MAX; i++) begin
				duty_reg[i] = '0;
				compare_reg[i] = '0;
			end
		endfunction

		function logic [15:0] scaled_compare(logic [15:0] top, logic [7:0] duty);
			int unsigned product;
			product = int'(top) * int'(duty);
			return 16'(product >> DUTY_SHIFT);
		endfunction

		function result_t predict_settings(cmd_t c);
			longint unsigned prescalers[NUM_PRESCALERS];
			longint unsigned trial;
			int idx;
			bit found;
			result_t r;
			prescalers = '{1, 8, 64, 256, 1024};
			r.ok = 1'b0;
			trial = 0;
			idx = 0;
			found = 0;
			if (c.func == FUNC_SET_FREQ) begin
				if (c.frequency != 0) begin
					for (int n = 0; n < NUM_PRESCALERS && !found; n++) begin
						trial = longint'(CLK_HZ) / (2 * prescalers[n] * longint'(c.frequency));
						if (trial > MIN_TOP_EXCL && trial <= 65535) begin
							found = 1;
							idx = n;
						end
					end
					if (found && trial < 65535) begin
						top_value = 16'(trial);
						for (int ch = 0; ch < NUM_CH_MAX; ch++)
							compare_reg[ch] = scaled_compare(top_value, duty_reg[ch]);
						enable_bits = 3'b111;
						prescale_code = 3'(idx + 1);
						r.ok = 1'b1;
					end
				end
			end else if (c.channel < NUM_CH_MAX) begin
				duty_reg[c.channel] = c.duty;
				compare_reg[c.channel] = scaled_compare(top_value, c.duty);
				enable_bits[c.channel] = 1'b1;
				r.ok = 1'b1;
			end
			r.period_top = top_value;
			r.clock_select = prescale_code;
			r.compare_a = compare_reg[0];
			r.compare_b = compare_reg[1];
			r.compare_c = compare_reg[2];
			r.output_enables = enable_bits;
			return r;
		endfunction

		function void note_command(cmd_t c);
			expected_settings.push_back(predict_settings(c));
		endfunction

		function int pending();
			return expected_settings.size();
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
				fails++;
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_settings.size() == 0) begin
				$display("%0t: result with none expected, actual %h", $time, got);
				fails++;
				return;
			end
			want = expected_settings.pop_front();
			compare_field("ok", want.ok, got.ok);
			compare_field("period_top", want.period_top, got.period_top);
			compare_field("clock_select", want.clock_select, got.clock_select);
			compare_field("compare_a", want.compare_a, got.compare_a);
			compare_field("compare_b", want.compare_b, got.compare_b);
			compare_field("compare_c", want.compare_c, got.compare_c);
			compare_field("output_enables", want.output_enables, got.output_enables);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	cmd_t cmd = '0;
	logic busy;
	logic done;
	result_t result;
	int cycle_count = 0;
	pwm_setup_scoreboard sb = new();

	pwm_frequency_and_duty_setup #(
		.CLOCK_HZ(CLK_HZ),
		.COUNTER_BITS(16),
		.CHANNELS(3)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.cmd(cmd),
		.busy(busy),
		.done(done),
		.result(result)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(result);
	end

	function automatic cmd_t make_cmd(logic func, int unsigned freq, int unsigned ch,
			int unsigned duty);
		cmd_t c;
		c.func = func;
		c.frequency = 24'(freq);
		c.channel = 2'(ch);
		c.duty = 8'(duty);
		return c;
	endfunction

	function automatic cmd_t random_cmd();
		int unsigned freq;
		case ($urandom_range(0, 9))
			0: freq = 0;
			1, 2: freq = $urandom_range(1, 300);
			3, 4: freq = $urandom_range(1, 70000);
			5: freq = $urandom_range(1900000, 2100000);
			6, 7: freq = $urandom & 24'hFFFFFF;
			default: freq = $urandom_range(100, 200000);
		endcase
		return make_cmd(($urandom_range(0, 99) < 35) ? FUNC_SET_FREQ : FUNC_SET_DUTY, freq,
			$urandom_range(0, 3), $urandom_range(0, 255));
	endfunction

	task automatic issue_command(cmd_t c);
		start <= 1'b1;
		cmd <= c;
		do
			@(posedge clk);
		while (busy);
		sb.note_command(c);
	endtask

	task automatic idle_cycles(int n);
		start <= 1'b0;
		cmd <= random_cmd();
		repeat (n) @(posedge clk);
	endtask

	task automatic drain_settings();
		start <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		cmd_t directed[$];
		int sent;
		int burst;
		bit paused;
		directed = '{
			make_cmd(FUNC_SET_DUTY, 0, 0, 128),
			make_cmd(FUNC_SET_DUTY, 24'hFFFFFF, 1, 255),
			make_cmd(FUNC_SET_DUTY, 0, 2, 0),
			make_cmd(FUNC_SET_DUTY, 0, 3, 77),
			make_cmd(FUNC_SET_FREQ, 0, 0, 0),
			make_cmd(FUNC_SET_FREQ, 1, 3, 255),
			make_cmd(FUNC_SET_FREQ, 122, 0, 0),
			make_cmd(FUNC_SET_FREQ, 123, 0, 0),
			make_cmd(FUNC_SET_FREQ, 2000000, 0, 0),
			make_cmd(FUNC_SET_FREQ, 2000001, 0, 0),
			make_cmd(FUNC_SET_FREQ, 24'hFFFFFF, 0, 0),
			make_cmd(FUNC_SET_FREQ, 1000, 0, 0),
			make_cmd(FUNC_SET_DUTY, 0, 0, 255),
			make_cmd(FUNC_SET_DUTY, 0, 1, 0),
			make_cmd(FUNC_SET_DUTY, 0, 2, 1),
			make_cmd(FUNC_SET_DUTY, 0, 3, 255),
			make_cmd(FUNC_SET_FREQ, 24'h800000, 0, 0),
			make_cmd(FUNC_SET_FREQ, 15, 0, 0),
			make_cmd(FUNC_SET_FREQ, 61, 0, 0),
			make_cmd(FUNC_SET_FREQ, 62, 0, 0),
			make_cmd(FUNC_SET_FREQ, 7812, 2, 200),
			make_cmd(FUNC_SET_DUTY, 24'h5A5A5A, 2, 255)
		};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i])
			issue_command(directed[i]);
		drain_settings();

		sent = 0;
		paused = 0;
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 24);
			for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
				issue_command(random_cmd());
				sent++;
			end
			if (!paused && sent >= RANDOM_ITEMS / 2) begin
				drain_settings();
				paused = 1;
			end else if ($urandom_range(0, 7) == 0) begin
				drain_settings();
			end else if ($urandom_range(0, 3) != 0) begin
				idle_cycles($urandom_range(1, 40));
			end
		end

		drain_settings();
		repeat (50) @(posedge clk);
		if (sb.fails == 0 && sb.pending() == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end
endmodule
